/* rtl/srgbpm_pkg.sv */
// Shared constants, types and elaboration-time table builders for the sRGB premultiplier.
`default_nettype none

package srgbpm_pkg;

    // Widest linear fraction that the tables are built for.
    localparam int LIN_BITS_MAX = 16;
    // Number of sRGB codes and of binary search steps over them.
    localparam int CODES        = 256;
    localparam int SEARCH_STEPS = 8;
    // Decode, multiply, reciprocal and correction stages ahead of the search.
    localparam int PRE_STAGES   = 4;
    localparam int PIPE_STAGES  = PRE_STAGES + SEARCH_STEPS;

    // Q30 fixed-point constants used only while building the tables.
    localparam longint unsigned Q_ONE  = 64'd1 << 30;
    localparam longint unsigned Q_HALF = 64'd1 << 29;

    typedef logic [LIN_BITS_MAX-1:0] t_dec_tab [CODES];
    typedef logic [LIN_BITS_MAX:0]   t_thr_tab [CODES];

    // Values that travel alongside each item for the pass-through path and alpha.
    typedef struct packed {
        logic       has_alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_side;

    // Rounded Q30 product.
    function automatic longint unsigned f_qmul(longint unsigned a, longint unsigned b);
        return (a * b + Q_HALF) >> 30;
    endfunction

    // Linear light of sRGB code n/510 in Q30, the power 2.4 found by bisection.
    function automatic longint unsigned f_lin(int unsigned n);
        longint unsigned b;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        if (n <= 20) begin
            return (longint'(n) * 64'd10 * Q_ONE + 64'd32946) / 64'd65892;
        end
        b = ((longint'(n) * 64'd20 + 64'd561) * Q_ONE + 64'd5380) / 64'd10761;
        if (b > Q_ONE) begin
            b = Q_ONE;
        end
        s  = f_qmul(b, b);
        lo = 64'd0;
        hi = Q_ONE;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            p   = f_qmul(f_qmul(f_qmul(f_qmul(mid, mid), mid), mid), mid);
            if (p <= s) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return f_qmul(s, lo);
    endfunction

    // Decode table: sRGB code to linear fraction scaled to 2^lin_bits - 1.
    function automatic t_dec_tab f_dec_table(int lin_bits);
        t_dec_tab        tab;
        longint unsigned scale;
        int              c;
        scale = (64'd1 << lin_bits) - 64'd1;
        for (c = 0; c < CODES; c++) begin
            tab[c] = LIN_BITS_MAX'((f_lin(2 * c) * scale + Q_HALF) >> 30);
        end
        return tab;
    endfunction

    // Encode thresholds: smallest linear level at or above each midpoint between
    // neighboring codes. The last entry lies above every level.
    function automatic t_thr_tab f_thr_table(int lin_bits);
        t_thr_tab        tab;
        longint unsigned scale;
        int              k;
        scale = (64'd1 << lin_bits) - 64'd1;
        for (k = 0; k < CODES - 1; k++) begin
            tab[k] = (LIN_BITS_MAX + 1)'((f_lin(2 * k + 1) * scale + Q_ONE - 64'd1) >> 30);
        end
        tab[CODES-1] = (LIN_BITS_MAX + 1)'(64'd1 << lin_bits);
        return tab;
    endfunction

endpackage

`default_nettype wire

/* rtl/srgbpm_premul.sv */
// One color lane: sRGB decode, multiply by alpha, divide by 255 with rounding.
`default_nettype none

module srgbpm_premul #(
    parameter int LINEAR_BITS       = 16,
    parameter int ENCODE_INDEX_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic [srgbpm_pkg::PRE_STAGES-1:0] i_en,
    input  wire logic [7:0]                        i_code,
    input  wire logic [7:0]                        i_alpha,
    output logic      [LINEAR_BITS-1:0]            o_level
);
    import srgbpm_pkg::*;

    localparam t_dec_tab DecTab = f_dec_table(LINEAR_BITS);
    localparam int ProdW    = LINEAR_BITS + 8;
    localparam int EstW     = ProdW + 9;
    localparam int QuotW    = EstW - 16;
    localparam int RemW     = ProdW + 1;
    localparam int DropBits = (ENCODE_INDEX_BITS < LINEAR_BITS) ?
                              (LINEAR_BITS - ENCODE_INDEX_BITS) : 0;
    localparam logic [LINEAR_BITS-1:0] KeepMask = {LINEAR_BITS{1'b1}} << DropBits;

    logic [LINEAR_BITS-1:0] r_lin;
    logic [7:0]             r_alpha;
    logic [ProdW-1:0]       r_prod;
    logic [ProdW-1:0]       r_prod_d;
    logic [QuotW-1:0]       r_est;
    logic [LINEAR_BITS-1:0] r_level;

    logic [ProdW-1:0]       n_prod;
    logic [EstW-1:0]        n_scaled;
    logic [RemW-1:0]        n_rem;
    logic [QuotW-1:0]       n_quot;
    logic [LINEAR_BITS-1:0] n_level;

    // Product plus half of the divisor, then the reciprocal estimate of x/255.
    always_comb begin
        n_prod   = ProdW'(r_lin) * ProdW'(r_alpha) + ProdW'(8'd127);
        n_scaled = (EstW'(r_prod) << 8) + EstW'(r_prod);
    end

    // The estimate is low by at most one; the remainder decides the correction.
    always_comb begin
        n_rem   = RemW'(r_prod_d) - (RemW'(r_est) << 8) + RemW'(r_est);
        n_quot  = (n_rem >= RemW'(9'd255)) ? (r_est + QuotW'(1)) : r_est;
        n_level = n_quot[LINEAR_BITS-1:0] & KeepMask;
    end

    // Stage 0: table decode.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lin   <= DecTab[i_code][LINEAR_BITS-1:0];
            r_alpha <= i_alpha;
        end
    end

    // Stage 1: multiply by alpha.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod <= n_prod;
        end
    end

    // Stage 2: multiply by the reciprocal of 255.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_est    <= n_scaled[EstW-1:16];
            r_prod_d <= r_prod;
        end
    end

    // Stage 3: corrected quotient, trimmed to the encode index resolution.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

/* rtl/srgbpm_encode.sv */
// Linear level to nearest sRGB code by a pipelined binary search over thresholds.
`default_nettype none

module srgbpm_encode #(
    parameter int LINEAR_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic [srgbpm_pkg::SEARCH_STEPS-1:0] i_en,
    input  wire logic [LINEAR_BITS-1:0]              i_level,
    output logic      [7:0]                          o_code
);
    import srgbpm_pkg::*;

    localparam t_thr_tab ThrTab = f_thr_table(LINEAR_BITS);

    logic [7:0]             r_pos [SEARCH_STEPS];
    logic [LINEAR_BITS-1:0] r_lev [SEARCH_STEPS-1];

    // Each stage settles one bit of the code, most significant first.
    for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_step
        localparam int         Bit      = SEARCH_STEPS - 1 - s;
        localparam logic [7:0] StepBit  = 8'(1 << Bit);
        localparam logic [7:0] ProbeLow = 8'((1 << Bit) - 1);

        logic [7:0]             pos_in;
        logic [LINEAR_BITS-1:0] lev_in;
        logic [7:0]             probe;
        logic                   hit;

        if (s == 0) begin : g_first
            assign pos_in = 8'd0;
            assign lev_in = i_level;
        end else begin : g_next
            assign pos_in = r_pos[s-1];
            assign lev_in = r_lev[s-1];
        end

        // The code is at least probe + 1 when that midpoint is not above the level.
        assign probe = pos_in | ProbeLow;
        assign hit   = ThrTab[probe][LINEAR_BITS:0] <= {1'b0, lev_in};

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_pos[s] <= hit ? (pos_in | StepBit) : pos_in;
            end
        end

        if (s < SEARCH_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_lev[s] <= lev_in;
                end
            end
        end
    end

    assign o_code = r_pos[SEARCH_STEPS-1];

endmodule

`default_nettype wire

/* rtl/srgb_premultiply_alpha_pixel_core.sv */
// Top level of the sRGB alpha premultiplier: handshakes, stage control, lanes, output select.
//
// One pixel (blue, green, red, alpha bytes) enters on the input channel per item and
// one converted pixel leaves on the output channel per item, in order. Both channels
// use valid and ready. The configuration channel carries the source_has_alpha bit and
// is always ready; write it only while no item is in flight.
// With source_has_alpha set, each color byte is decoded to linear light, scaled by
// alpha/255 with rounding and encoded back to the nearest sRGB byte; alpha passes
// through. With it clear, the colors pass through and alpha comes out as 255.
// An item passes through 4 stages of decode and divide, then 8 stages of the encode
// search, before it shows on the output. Throughput: one item per cycle while the
// receiver takes items. Every stage has its own valid bit and loads whenever it is
// empty or its successor moves, so bubbles close up and input ready stays high while
// any stage is free.
// When the receiver stalls, the pipeline fills behind the held output item and input
// ready drops only once all 12 stages hold items.
// Reset (synchronous, active low) empties the pipeline and sets source_has_alpha to 1.
`default_nettype none

module srgb_premultiply_alpha_pixel_core #(
    parameter int LINEAR_BITS       = 16,
    parameter int ENCODE_INDEX_BITS = 12
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write channel.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_source_has_alpha,
    // Input pixel channel.
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_blue_in,
    input  wire logic [7:0] i_green_in,
    input  wire logic [7:0] i_red_in,
    input  wire logic [7:0] i_alpha_in,
    // Output pixel channel.
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_blue_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_red_out,
    output logic [7:0]      o_alpha_out
);
    import srgbpm_pkg::*;

    localparam int Last = PIPE_STAGES - 1;

    logic                    r_has_alpha;
    logic [PIPE_STAGES-1:0]  r_vld;
    logic [PIPE_STAGES-1:0]  w_en;
    t_side                   r_side [PIPE_STAGES];

    logic [LINEAR_BITS-1:0]  w_lev_b;
    logic [LINEAR_BITS-1:0]  w_lev_g;
    logic [LINEAR_BITS-1:0]  w_lev_r;
    logic [7:0]              w_code_b;
    logic [7:0]              w_code_g;
    logic [7:0]              w_code_r;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_alpha <= 1'b1;
        end else if (i_cfg_valid) begin
            r_has_alpha <= i_cfg_source_has_alpha;
        end
    end

    // A stage loads when it is empty or its successor takes its item.
    always_comb begin
        w_en[Last] = !r_vld[Last] || i_out_ready;
        for (int k = Last - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[0];

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Side values: mode, raw bytes and alpha for each item.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= '{has_alpha: r_has_alpha, blue: i_blue_in, green: i_green_in,
                           red: i_red_in, alpha: i_alpha_in};
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Color lanes: decode and premultiply.
    srgbpm_premul #(
        .LINEAR_BITS       (LINEAR_BITS),
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_premul_b (
        .i_clk   (i_clk),
        .i_en    (w_en[PRE_STAGES-1:0]),
        .i_code  (i_blue_in),
        .i_alpha (i_alpha_in),
        .o_level (w_lev_b)
    );

    srgbpm_premul #(
        .LINEAR_BITS       (LINEAR_BITS),
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_premul_g (
        .i_clk   (i_clk),
        .i_en    (w_en[PRE_STAGES-1:0]),
        .i_code  (i_green_in),
        .i_alpha (i_alpha_in),
        .o_level (w_lev_g)
    );

    srgbpm_premul #(
        .LINEAR_BITS       (LINEAR_BITS),
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_premul_r (
        .i_clk   (i_clk),
        .i_en    (w_en[PRE_STAGES-1:0]),
        .i_code  (i_red_in),
        .i_alpha (i_alpha_in),
        .o_level (w_lev_r)
    );

    // Color lanes: encode back to sRGB.
    srgbpm_encode #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_encode_b (
        .i_clk   (i_clk),
        .i_en    (w_en[Last:PRE_STAGES]),
        .i_level (w_lev_b),
        .o_code  (w_code_b)
    );

    srgbpm_encode #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_encode_g (
        .i_clk   (i_clk),
        .i_en    (w_en[Last:PRE_STAGES]),
        .i_level (w_lev_g),
        .o_code  (w_code_g)
    );

    srgbpm_encode #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_encode_r (
        .i_clk   (i_clk),
        .i_en    (w_en[Last:PRE_STAGES]),
        .i_level (w_lev_r),
        .o_code  (w_code_r)
    );

    // Output select between premultiplied and passed-through pixels.
    always_comb begin
        if (r_side[Last].has_alpha) begin
            o_blue_out  = w_code_b;
            o_green_out = w_code_g;
            o_red_out   = w_code_r;
            o_alpha_out = r_side[Last].alpha;
        end else begin
            o_blue_out  = r_side[Last].blue;
            o_green_out = r_side[Last].green;
            o_red_out   = r_side[Last].red;
            o_alpha_out = 8'hFF;
        end
    end

    assign o_out_valid = r_vld[Last];

    // Input is refused only when every stage holds an item.
    a_ready_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld)
    ) else $error("input refused while a stage is free");

    // An empty pipeline cannot present an item in the next cycle.
    a_no_invented_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |=> !o_out_valid
    ) else $error("output item appeared from an empty pipeline");

    // Fully transparent premultiplied pixels come out black.
    a_zero_alpha_black: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_side[Last].has_alpha && (o_alpha_out == 8'd0)) |->
        ((o_blue_out == 8'd0) && (o_green_out == 8'd0) && (o_red_out == 8'd0))
    ) else $error("zero alpha gave a nonzero color");

endmodule

`default_nettype wire
